### rtl/p2f_pkg.sv
// Package for the packet to flit segmenter: sizes, item types, flit kind codes.
`default_nettype none
package p2f_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int NODE_COUNT  = 64;
  localparam int MAX_FLITS   = 32;

  localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int LEN_W   = $clog2(MAX_FLITS + 1);
  localparam int NODE_W  = 6;
  localparam int STAMP_W = 32;
  localparam int PLEN_W  = 6;
  localparam int SEQ_W   = 5;

  typedef enum logic [1:0] {
    KIND_HEAD = 2'd0,
    KIND_BODY = 2'd1,
    KIND_TAIL = 2'd2
  } flit_kind_t;

  typedef struct packed {
    logic               inject;
    logic [NODE_W-1:0]  pkt_source;
    logic [NODE_W-1:0]  pkt_target;
    logic [STAMP_W-1:0] pkt_stamp;
    logic [PLEN_W-1:0]  pkt_length;
    logic               ack_level;
  } p2f_in_t;

  typedef struct packed {
    logic               flit_valid;
    logic [NODE_W-1:0]  flit_source;
    logic [NODE_W-1:0]  flit_target;
    logic [STAMP_W-1:0] flit_stamp;
    logic [SEQ_W-1:0]   flit_seq;
    flit_kind_t         flit_kind;
    logic               req_level;
    logic               drop_flag;
  } p2f_out_t;

  // one queued packet; length already clamped to 1..MAX_FLITS
  typedef struct packed {
    logic [NODE_W-1:0]  src;
    logic [NODE_W-1:0]  dst;
    logic [STAMP_W-1:0] stamp;
    logic [LEN_W-1:0]   len;
  } p2f_entry_t;

endpackage
`default_nettype wire

### rtl/p2f_if.sv
// Valid/ready channel interfaces for input ticks and result items.
`default_nettype none
interface p2f_in_if
  import p2f_pkg::*;
  ();
  logic    valid;
  logic    ready;
  p2f_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface p2f_out_if
  import p2f_pkg::*;
  ();
  logic     valid;
  logic     ready;
  p2f_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/packet_to_flit_tx_handshake.sv
// Packet to flit transmit segmenter with alternating-bit request/acknowledge.
//
// in_ch carries one item per network tick: an optional packet descriptor
// (inject, source, target, stamp, length) and the router's ack level.
// out_ch returns exactly one item per input item: the flit sent on that
// tick (or all-zero flit fields when none is sent), the request level after
// the tick, and a drop flag when the 16-entry packet queue was full.
// A packet injected into an empty queue can send its head flit on the
// same tick.
// The input item is held in an input register; the queue update and flit
// build then feed the result register.
// Items are taken at one per cycle while out_ch.ready stays high; the queue
// read, count update and flit kind/sequence logic all settle in a single
// register-to-register pass.
// When the receiver stalls, the result register holds and one more item is
// taken into the input register; after that in_ch.ready drops until
// out_ch.ready returns.
// Reset clears pointers, count, flit progress and the request level; queue
// entries are not cleared and are only read after being written.
`default_nettype none
module packet_to_flit_tx_handshake
  import p2f_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  p2f_in_if.sink     in_ch,
  p2f_out_if.source  out_ch
);

  p2f_entry_t store_r [QUEUE_DEPTH];

  p2f_in_t          in_r;
  logic             in_valid_r;
  p2f_out_t         out_r, out_nxt;
  logic             out_valid_r;

  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic             send_level_r, send_level_nxt;

  logic             advance;
  logic             full;
  logic             push;
  logic             send;
  logic             pop;
  p2f_entry_t       new_entry;
  p2f_entry_t       front;
  logic [LEN_W-1:0] left;
  logic [LEN_W-1:0] left_dec;

  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  assign full = (count_r == CNT_W'(QUEUE_DEPTH));
  assign push = in_r.inject && !full;

  always_comb begin
    new_entry.src   = in_r.pkt_source;
    new_entry.dst   = in_r.pkt_target;
    new_entry.stamp = in_r.pkt_stamp;
    if (in_r.pkt_length == '0) begin
      new_entry.len = LEN_W'(1);
    end else if (32'(in_r.pkt_length) > MAX_FLITS) begin
      new_entry.len = LEN_W'(MAX_FLITS);
    end else begin
      new_entry.len = LEN_W'(in_r.pkt_length);
    end
  end

  // empty queue: the packet pushed this tick is the front one
  assign front = (count_r == '0) ? new_entry : store_r[head_r];
  assign send  = (in_r.ack_level == send_level_r) && ((count_r != '0) || push);
  assign left  = ((rem_r == '0) || (rem_r > front.len)) ? front.len : rem_r;
  assign left_dec = left - LEN_W'(1);
  assign pop   = send && (left_dec == '0);

  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    rem_nxt        = rem_r;
    send_level_nxt = send_level_r;
    count_nxt      = count_r + CNT_W'(push) - CNT_W'(pop);
    if (push) begin
      tail_nxt = (tail_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + PTR_W'(1);
    end
    if (pop) begin
      head_nxt = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
    end
    if (send) begin
      rem_nxt        = left_dec;
      send_level_nxt = !send_level_r;
    end
  end

  always_comb begin
    out_nxt           = '0;
    out_nxt.req_level = send_level_nxt;
    out_nxt.drop_flag = in_r.inject && full;
    if (send) begin
      out_nxt.flit_valid  = 1'b1;
      out_nxt.flit_source = front.src;
      out_nxt.flit_target = front.dst;
      out_nxt.flit_stamp  = front.stamp;
      out_nxt.flit_seq    = SEQ_W'(front.len - left);
      if (left == front.len) begin
        out_nxt.flit_kind = KIND_HEAD;
      end else if (left == LEN_W'(1)) begin
        out_nxt.flit_kind = KIND_TAIL;
      end else begin
        out_nxt.flit_kind = KIND_BODY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      head_r       <= '0;
      tail_r       <= '0;
      count_r      <= '0;
      rem_r        <= '0;
      send_level_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r  <= 1'b1;
        head_r       <= head_nxt;
        tail_r       <= tail_nxt;
        count_r      <= count_nxt;
        rem_r        <= rem_nxt;
        send_level_r <= send_level_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_r <= in_ch.data;
    end
    if (advance) begin
      out_r <= out_nxt;
    end
    if (advance && push) begin
      store_r[tail_r] <= new_entry;
    end
  end

  // queue occupancy never exceeds its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("packet queue count above depth");

  // an empty queue has matching pointers
  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (head_r == tail_r))
    else $error("empty queue with pointer mismatch");

  // request level only moves on a tick that is processed
  a_level_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(send_level_r))
    else $error("request level changed without a processed item");

  // a waiting input item is held until it is processed
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> (in_valid_r && $stable(in_r)))
    else $error("pending input item lost");

  // a flit that starts a packet is always typed head
  a_head_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && send && (rem_r == '0)) |-> (out_nxt.flit_kind == KIND_HEAD))
    else $error("first flit of packet not typed head");

endmodule
`default_nettype wire
